/* hdl/fpa_pkg.sv */
package fpa_pkg;

    localparam int OP_W   = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int FRAC_W = 5;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [STAT_W-1:0] t_status;
    typedef logic [FRAC_W-1:0] t_frac;

    localparam t_op OP_ADD  = 3'd0;
    localparam t_op OP_SUB  = 3'd1;
    localparam t_op OP_MUL  = 3'd2;
    localparam t_op OP_DIV  = 3'd3;
    localparam t_op OP_ADDC = 3'd4;
    localparam t_op OP_SUBC = 3'd5;
    localparam t_op OP_MULC = 3'd6;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_OVF  = 2'd1;
    localparam t_status ST_DIVZ = 2'd2;

    localparam t_frac FRAC_RESET = 5'd31;

endpackage

/* hdl/fpa_if.sv */
interface fpa_in_if;
    logic                             valid;
    logic                             ready;
    fpa_pkg::t_op                     op;
    logic signed [fpa_pkg::DATA_W-1:0] operand_a;
    logic signed [fpa_pkg::DATA_W-1:0] operand_b;
    modport source (output valid, op, operand_a, operand_b, input ready);
    modport sink   (input valid, op, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [fpa_pkg::DATA_W-1:0] result;
    fpa_pkg::t_status                 status;
    modport source (output valid, result, status, input ready);
    modport sink   (input valid, result, status, output ready);
endinterface

interface fpa_cfg_if;
    logic                 valid;
    logic                 ready;
    fpa_pkg::t_frac       data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* hdl/fixed_point_alu_top.sv */
// channel | dir | payload                    | word accepted when
// i_in    | in  | op, operand_a, operand_b   | valid && ready
// o_out   | out | result, status             | valid && ready
// i_cfg   | in  | data (frac_bits)           | valid && ready (always ready)
//
// one word enters per cycle while the output is not stalled; most of the pipeline is
// the divider, which retires two quotient bits per stage
// synchronous active-low reset clears the valid bits and sets frac_bits to 31
// a stalled output freezes the whole pipeline; nothing is dropped or repeated
module fixed_point_alu_top #(
    parameter int WORD_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpa_in_if.sink    i_in,
    fpa_out_if.source o_out,
    fpa_cfg_if.sink   i_cfg
);
    import fpa_pkg::*;

    localparam int W     = WORD_WIDTH;
    localparam int NUM_W = W + 32;
    localparam int K     = (NUM_W + 1) / 2;
    localparam int NUM_P = 2 * K;

    typedef struct packed {
        t_op          op;
        logic [W-1:0] alt_res;
        t_status      alt_st;
        logic         qneg;
        logic         dz;
    } t_side;

    // configuration
    t_frac r_frac;
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac <= FRAC_RESET;
        end else if (i_cfg.valid) begin
            r_frac <= i_cfg.data;
        end
    end

    // global advance
    logic r_ov;
    logic en;
    assign en = !r_ov || o_out.ready;
    assign i_in.ready = en;

    // stage 1: capture operands
    logic                r_v1;
    t_op                 r_op1;
    logic signed [W-1:0] r_a1, r_b1;
    t_frac               r_n1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in.valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op1 <= i_in.op;
            r_a1  <= W'(i_in.operand_a);
            r_b1  <= W'(i_in.operand_b);
            r_n1  <= r_frac;
        end
    end

    // stage 2: sum, difference, product, scaled dividend
    logic                    r_v2;
    t_op                     r_op2;
    t_frac                   r_n2;
    logic signed [W:0]       r_sum2, r_dif2;
    logic signed [NUM_W-1:0] r_prod2;
    logic signed [NUM_W-1:0] r_num2;
    logic signed [W-1:0]     r_b2;
    logic signed [W:0]       n_bh;
    // divisor halved, truncated toward zero
    always_comb begin
        n_bh = ((W+1)'(r_b1) + $signed((W+1)'(r_b1 < 0))) >>> 1;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op2   <= r_op1;
            r_n2    <= r_n1;
            r_b2    <= r_b1;
            r_sum2  <= (W+1)'(r_a1) + (W+1)'(r_b1);
            r_dif2  <= (W+1)'(r_a1) - (W+1)'(r_b1);
            r_prod2 <= NUM_W'(r_a1) * NUM_W'(r_b1);
            r_num2  <= (NUM_W'(r_a1) <<< r_n1) + NUM_W'(n_bh);
        end
    end

    // stage 3: rounding, overflow checks, divider set-up
    logic signed [NUM_W-1:0] n_pr, n_ps;
    logic                    n_mfit;
    t_side                   n_side;
    logic [NUM_W-1:0]        n_nmag;
    logic [W-1:0]            n_dmag;
    always_comb begin
        n_pr = r_prod2;
        if (r_n2 != '0) begin
            n_pr = r_prod2 + (NUM_W'(1) << (r_n2 - t_frac'(1)));
        end
        n_ps   = n_pr >>> r_n2;
        n_mfit = (n_ps[NUM_W-1:W-1] == '0) || (n_ps[NUM_W-1:W-1] == '1);
        n_side.op      = r_op2;
        n_side.alt_res = '0;
        n_side.alt_st  = ST_OK;
        n_side.qneg    = r_num2[NUM_W-1] ^ r_b2[W-1];
        n_side.dz      = (r_b2 == '0);
        case (r_op2)
            OP_ADD: n_side.alt_res = r_sum2[W-1:0];
            OP_SUB: n_side.alt_res = r_dif2[W-1:0];
            OP_MUL: n_side.alt_res = n_ps[W-1:0];
            OP_ADDC: begin
                if (r_sum2[W] != r_sum2[W-1]) n_side.alt_st = ST_OVF;
                else n_side.alt_res = r_sum2[W-1:0];
            end
            OP_SUBC: begin
                if (r_dif2[W] != r_dif2[W-1]) n_side.alt_st = ST_OVF;
                else n_side.alt_res = r_dif2[W-1:0];
            end
            OP_MULC: begin
                if (!n_mfit) n_side.alt_st = ST_OVF;
                else n_side.alt_res = n_ps[W-1:0];
            end
            default: n_side.alt_res = '0;
        endcase
        n_nmag = r_num2[NUM_W-1] ? NUM_W'(-r_num2) : NUM_W'(r_num2);
        n_dmag = r_b2[W-1] ? W'(-r_b2) : W'(r_b2);
    end

    // divider pipeline, two quotient bits per stage
    logic             r_dv_v   [0:K];
    t_side            r_dv_sd  [0:K];
    logic [W-1:0]     r_dv_rem [0:K];
    logic [NUM_P-1:0] r_dv_num [0:K];
    logic [W-1:0]     r_dv_den [0:K];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (en) begin
            r_dv_v[0] <= r_v2;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_sd[0]  <= n_side;
            r_dv_rem[0] <= '0;
            r_dv_num[0] <= NUM_P'(n_nmag);
            r_dv_den[0] <= n_dmag;
        end
    end

    for (genvar s = 1; s <= K; s++) begin : g_div
        logic [W-1:0]     n_rem;
        logic [NUM_P-1:0] n_num;
        logic [W:0]       n_t;
        always_comb begin
            n_rem = r_dv_rem[s-1];
            n_num = r_dv_num[s-1];
            n_t   = '0;
            for (int j = 0; j < 2; j++) begin
                n_t   = {n_rem, n_num[NUM_P-1]};
                n_num = n_num << 1;
                if (n_t >= {1'b0, r_dv_den[s-1]}) begin
                    n_t      = n_t - {1'b0, r_dv_den[s-1]};
                    n_num[0] = 1'b1;
                end
                n_rem = n_t[W-1:0];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[s] <= 1'b0;
            end else if (en) begin
                r_dv_v[s] <= r_dv_v[s-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_sd[s]  <= r_dv_sd[s-1];
                r_dv_rem[s] <= n_rem;
                r_dv_num[s] <= n_num;
                r_dv_den[s] <= r_dv_den[s-1];
            end
        end
    end

    // final select into the output register
    t_side               n_fs;
    logic [W-1:0]        n_q;
    logic signed [W-1:0] n_res;
    t_status             n_st;
    always_comb begin
        n_fs  = r_dv_sd[K];
        n_q   = r_dv_num[K][W-1:0];
        n_res = n_fs.alt_res;
        n_st  = n_fs.alt_st;
        if (n_fs.op == OP_DIV) begin
            if (n_fs.dz) begin
                n_res = '0;
                n_st  = ST_DIVZ;
            end else begin
                n_res = n_fs.qneg ? -n_q : n_q;
                n_st  = ST_OK;
            end
        end
    end

    logic                     r_res;
    logic signed [DATA_W-1:0] r_out_res;
    t_status                  r_out_st;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_dv_v[K];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_res <= DATA_W'(n_res);
            r_out_st  <= n_st;
        end
    end
    assign r_res        = r_ov;
    assign o_out.valid  = r_res;
    assign o_out.result = r_out_res;
    assign o_out.status = r_out_st;

`ifndef SYNTH
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.status == ST_OK || o_out.status == ST_OVF
                         || o_out.status == ST_DIVZ))
        else $error("bad status code");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_OK) |-> (o_out.result == '0))
        else $error("flagged result not zero");
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r_v1) && $stable(r_v2) && $stable(r_dv_v[K])))
        else $error("pipeline moved during stall");
    a_input_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && en) |=> r_v1)
        else $error("accepted word lost at entry");
`endif

endmodule

/* test/fixed_point_alu_top_tb.sv */
module fixed_point_alu_top_tb;
    import fpa_pkg::*;

    // pipeline depth of the block, used for settling and the idle pause
    localparam int LATENCY   = 4 + (32 + 33) / 2;
    localparam int STALL_LIM = 20000;

    logic i_clk;
    logic i_rst_n;

    fpa_in_if  in_if ();
    fpa_out_if out_if ();
    fpa_cfg_if cfg_if ();

    fixed_point_alu_top #(.WORD_WIDTH(32)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .i_cfg   (cfg_if.sink)
    );

    typedef struct packed {
        logic signed [31:0] value;
        t_status            status;
    } t_alu_word;

    // arithmetic shift right of a 64-bit value, rounding toward minus infinity
    function automatic logic signed [63:0] shift_down(logic signed [63:0] v, int n);
        return v >>> n;
    endfunction

    // expected word for one operation under the current format
    function automatic t_alu_word compute_alu(t_op op, logic signed [31:0] a,
                                              logic signed [31:0] b, t_frac n);
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        logic signed [63:0] r;
        logic signed [63:0] num;
        t_alu_word w;
        wa = a;
        wb = b;
        r = 0;
        w.status = ST_OK;
        case (op)
            OP_ADD, OP_ADDC: r = wa + wb;
            OP_SUB, OP_SUBC: r = wa - wb;
            OP_MUL, OP_MULC: begin
                r = wa * wb;
                if (n != 0) r = r + (64'sd1 <<< (n - 1));
                r = shift_down(r, n);
            end
            OP_DIV: begin
                if (wb == 0) begin
                    w.status = ST_DIVZ;
                end else begin
                    num = (wa <<< n) + wb / 2;
                    r = num / wb;
                end
            end
            default: r = 0;
        endcase
        if ((op == OP_ADDC || op == OP_SUBC || op == OP_MULC) &&
            (r > 64'sd2147483647 || r < -64'sd2147483648)) begin
            w.status = ST_OVF;
        end
        w.value = (w.status == ST_OK) ? r[31:0] : 32'sd0;
        return w;
    endfunction

    int errors = 0;

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // expected words in order of acceptance
    class alu_scoreboard;
        t_alu_word pending[$];
        t_frac     frac;

        function void note_word(t_op op, logic signed [31:0] a, logic signed [31:0] b);
            pending.push_back(compute_alu(op, a, b, frac));
        endfunction

        task check_word(logic signed [31:0] value, t_status status);
            t_alu_word w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected word", value, 0);
                return;
            end
            w = pending.pop_front();
            if (value !== w.value) report_mismatch("result", value, w.value);
            if (status !== w.status) report_mismatch("status", status, w.status);
        endtask
    endclass

    alu_scoreboard sb;

    int  src_idle;
    int  snk_idle;
    bit  hold_sink;
    int  idle_cycles;
    bit  timed_out;

    typedef struct {
        t_op op;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_alu_req;
    t_alu_req reqs[$];

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // accept monitor and checks on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                sb.note_word(in_if.op, in_if.operand_a, in_if.operand_b);
            if (out_if.valid && out_if.ready)
                sb.check_word(out_if.result, out_if.status);
            if (cfg_if.valid && cfg_if.ready)
                sb.frac = cfg_if.data;
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (idle_cycles >= STALL_LIM && !timed_out) begin
            timed_out = 1;
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver ready, random or held off
    always @(negedge i_clk) begin
        if (!i_rst_n) out_if.ready <= 1'b0;
        else out_if.ready <= !hold_sink && ($urandom_range(99) >= snk_idle);
    end

    task automatic write_frac(t_frac n);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= n;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // offers queued words, with random gaps
    task automatic send_words();
        t_alu_req r;
        while (reqs.size() > 0) begin
            r = reqs.pop_front();
            while ($urandom_range(99) < src_idle) begin
                in_if.valid <= 1'b0;
                @(negedge i_clk);
            end
            in_if.valid     <= 1'b1;
            in_if.op        <= r.op;
            in_if.operand_a <= r.a;
            in_if.operand_b <= r.b;
            do @(posedge i_clk); while (!in_if.ready);
            @(negedge i_clk);
        end
        in_if.valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() > 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(5))
            0: return $urandom_range(15) - 8;
            1: return 32'sh7fffffff - $urandom_range(3);
            2: return 32'sh80000000 + $urandom_range(3);
            3: return $signed($urandom) >>> $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random(int count);
        t_alu_req r;
        repeat (count) begin
            r.op = t_op'($urandom_range(7));
            r.a  = rand_operand();
            r.b  = (r.op == OP_DIV && $urandom_range(9) == 0) ? 32'sd0 : rand_operand();
            reqs.push_back(r);
        end
    endtask

    task automatic queue_directed();
        logic signed [31:0] vals[6] = '{32'sh7fffffff, 32'sh80000000, 0, 1, -1,
                                        32'sh55555555};
        t_alu_req r;
        for (int o = 0; o < 8; o++) begin
            for (int k = 0; k < 3; k++) begin
                r.op = t_op'(o);
                r.a  = vals[(o + k) % 6];
                r.b  = vals[(o + 2 * k + 1) % 6];
                if (o == OP_DIV && k == 2) r.b = 0;
                reqs.push_back(r);
            end
        end
    endtask

    initial begin
        t_frac fracs[5] = '{5'd31, 5'd1, 5'd16, 5'd0, 5'd8};
        sb = new();
        sb.frac = FRAC_RESET;
        i_rst_n = 0;
        in_if.valid = 0;
        in_if.op = OP_ADD;
        in_if.operand_a = 0;
        in_if.operand_b = 0;
        cfg_if.valid = 0;
        cfg_if.data = 0;
        out_if.ready = 0;
        src_idle = 14;
        snk_idle = 72;
        hold_sink = 0;
        idle_cycles = 0;
        timed_out = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset format first, then each setting with directed and random words
        queue_directed();
        send_words();
        drain();
        for (int p = 0; p < 5; p++) begin
            write_frac(fracs[p]);
            if (p == 2) begin
                src_idle = 72;
                snk_idle = 14;
            end else if (p == 4) begin
                src_idle = 0;
                snk_idle = 0;
            end
            if (p == 3) begin
                // long hold-off on the output while words keep coming
                hold_sink = 1;
                fork
                    begin
                        repeat (200) @(negedge i_clk);
                        hold_sink = 0;
                    end
                join_none
            end
            queue_directed();
            queue_random(360);
            send_words();
            drain();
        end

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
